### rtl/tldg_pkg.sv
package tldg_pkg;

    // sequencer states: sizing steps first, then the word emit steps
    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_WH,
        S_TEST,
        S_MUL_BLK,
        S_MUL_TILES,
        S_LIST,
        S_DESC,
        S_CHECK,
        S_ERR_SPACE,
        S_ERR_DONE,
        S_TILE0,
        S_TILE1,
        S_TILE2,
        S_TILE3,
        S_TERM0,
        S_TERM1
    } t_state;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_NO_SPACE = 2'd1,
        STAT_FINISHED = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        REG_FRAME_WIDTH     = 2'd0,
        REG_FRAME_HEIGHT    = 2'd1,
        REG_BASE_ADDRESS    = 2'd2,
        REG_AVAILABLE_BYTES = 2'd3
    } t_reg_idx;

    localparam int FRAME_W      = 12;
    localparam int AVAIL_W      = 25;
    localparam int GRID_W       = 9;
    localparam int SHIFT_W      = 4;
    localparam int SUB_W        = 8;
    localparam int TILE_SHIFT   = 4;
    localparam int TILE_PIX     = 16;
    localparam int MUL_A_W      = 17;
    localparam int TILES_W      = 17;
    localparam int AREA_ALIGN   = 64;
    localparam int PAGE_BYTES   = 4096;
    localparam int LIST_SHIFT   = 2;
    localparam int DESC_SHIFT   = 4;
    localparam int DESC_BYTES   = 16;

    localparam logic [31:0] WORD_TILE_XY    = 32'hB800_0000;
    localparam logic [31:0] WORD_ADDR_SET   = 32'hE000_0002;
    localparam logic [31:0] WORD_ADDR_MASK  = 32'hE000_0003;
    localparam logic [31:0] WORD_TILE_END   = 32'hB000_0000;
    localparam logic [31:0] WORD_STREAM_END = 32'hBC00_0000;

endpackage

### rtl/tldg_mul.sv
module tldg_mul #(
    parameter int A_W = 17,
    parameter int B_W = 13
) (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic [A_W-1:0]     i_a,
    input  logic [B_W-1:0]     i_b,
    output logic [A_W+B_W-1:0] o_prod
);

    logic [A_W+B_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= i_a * i_b;
        end
    end

    assign o_prod = r_prod;

endmodule

### rtl/tile_list_descriptor_generator.sv
// tile list descriptor generator
//
// input channel: i_in_valid / o_in_stall carrying i_restart. output channel:
// o_out_valid / i_out_stall carrying o_word, o_last, o_stream_end, o_status.
// the user writes registers over the apb port only while the block is idle;
// the block itself does not enforce this.
// a restart transfer sizes the frame with one shared multiplier under the
// sequencer: it is accepted in idle, then the block count test repeats,
// halving the larger block dimension each time, until the count fits; the
// layout arithmetic follows. a restart that fits gives no result; one that
// does not gives a single error word. a continue transfer emits one word
// per cycle from the output register while the receiver does not stall:
// four words per tile, plus the two terminator words after the last tile.
// only one item is worked at a time; o_in_stall is high while the sequencer
// is busy after an accept, until the item's last word has been loaded.
// when the receiver stalls, the output register holds its word and the
// sequencer waits; no word is lost or repeated.
// after reset the registers hold their defaults and the stream counts as
// finished, so a continue before any restart returns a finished status.
module tile_list_descriptor_generator
    import tldg_pkg::*;
#(
    parameter int MAX_BLOCKS  = 320,
    parameter int BLOCK_BYTES = 512
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_restart,

    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_word,
    output logic        o_last,
    output logic        o_stream_end,
    output logic [1:0]  o_status,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int BB_W    = $clog2(BLOCK_BYTES + 1);
    localparam int B_W     = (BB_W > GRID_W) ? BB_W : GRID_W;
    localparam int P_W     = MUL_A_W + B_W;
    localparam int BO_W    = $clog2(MAX_BLOCKS * BLOCK_BYTES + 1);
    localparam int ACC_W   = ((BO_W > 21) ? BO_W : 21) + 2;
    localparam int CMP_W   = (ACC_W > AVAIL_W) ? ACC_W : AVAIL_W;

    // configuration
    logic [FRAME_W-1:0] r_frame_w;
    logic [FRAME_W-1:0] r_frame_h;
    logic [31:0]        r_base;
    logic [AVAIL_W-1:0] r_avail;

    // walk state
    t_state             r_state, n_state;
    logic               r_running, n_running;
    logic [GRID_W-1:0]  r_w, n_w;
    logic [GRID_W-1:0]  r_h, n_h;
    logic [SHIFT_W-1:0] r_shift_cols, n_shift_cols;
    logic [SHIFT_W-1:0] r_shift_rows, n_shift_rows;
    logic [GRID_W-1:0]  r_tile_cols, n_tile_cols;
    logic [GRID_W-1:0]  r_tile_rows, n_tile_rows;
    logic [GRID_W-1:0]  r_super_x, n_super_x;
    logic [GRID_W-1:0]  r_super_y, n_super_y;
    logic [SUB_W-1:0]   r_sub_i, n_sub_i;
    logic [SUB_W-1:0]   r_sub_j, n_sub_j;
    logic [BO_W-1:0]    r_block_offset, n_block_offset;
    logic [ACC_W-1:0]   r_acc, n_acc;

    // output register
    logic               r_out_valid;
    logic [31:0]        r_word;
    logic               r_last;
    logic               r_end;
    t_status            r_status;

    logic               w_accept;
    logic               w_cfg_wr;
    logic               w_emit;
    logic               w_load;
    logic               w_has_tile;
    logic               w_over;
    logic               w_fits;
    logic               w_done_after;

    logic               w_mul_en;
    logic [MUL_A_W-1:0] w_mul_a;
    logic [B_W-1:0]     w_mul_b;
    logic [P_W-1:0]     w_prod;

    logic [GRID_W-1:0]  w_step_x;
    logic [GRID_W-1:0]  w_step_y;
    logic [GRID_W:0]    w_inc_i;
    logic [GRID_W:0]    w_inc_j;
    logic [GRID_W:0]    w_next_x;
    logic [GRID_W:0]    w_next_y;
    logic [SUB_W-1:0]   c_sub_i, c_sub_j;
    logic [GRID_W-1:0]  c_super_x, c_super_y;
    logic [BO_W-1:0]    c_block_offset;
    logic [GRID_W:0]    c_super_y_full;

    logic [FRAME_W:0]   w_round_w;
    logic [FRAME_W:0]   w_round_h;
    logic [MUL_A_W-1:0] w_cols_wide;
    logic [MUL_A_W-1:0] w_rows_wide;
    logic [ACC_W-1:0]   w_list_sum;
    logic [ACC_W-1:0]   w_desc_sum;
    logic [ACC_W-1:0]   w_blk_sum;
    logic [TILES_W-1:0] w_tiles;
    logic [31:0]        w_addr;
    logic [SUB_W-1:0]   w_x;
    logic [SUB_W-1:0]   w_y;

    logic [31:0]        e_word;
    logic               e_last;
    logic               e_end;
    t_status            e_status;

    tldg_mul #(
        .A_W (MUL_A_W),
        .B_W (B_W)
    ) u_mul (
        .i_clk  (i_clk),
        .i_en   (w_mul_en),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    assign pready     = 1'b1;
    assign w_cfg_wr   = psel && penable && pwrite && pready;
    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;

    always_comb begin
        unique case (t_reg_idx'(paddr[3:2]))
            REG_FRAME_WIDTH:     prdata = {{(32-FRAME_W){1'b0}}, r_frame_w};
            REG_FRAME_HEIGHT:    prdata = {{(32-FRAME_W){1'b0}}, r_frame_h};
            REG_BASE_ADDRESS:    prdata = r_base;
            REG_AVAILABLE_BYTES: prdata = {{(32-AVAIL_W){1'b0}}, r_avail};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_w <= FRAME_W'(TILE_PIX);
            r_frame_h <= FRAME_W'(TILE_PIX);
            r_base    <= '0;
            r_avail   <= AVAIL_W'(1048576);
        end else if (w_cfg_wr) begin
            unique case (t_reg_idx'(paddr[3:2]))
                REG_FRAME_WIDTH:     r_frame_w <= pwdata[FRAME_W-1:0];
                REG_FRAME_HEIGHT:    r_frame_h <= pwdata[FRAME_W-1:0];
                REG_BASE_ADDRESS:    r_base    <= pwdata;
                REG_AVAILABLE_BYTES: r_avail   <= pwdata[AVAIL_W-1:0];
            endcase
        end
    end

    // tile and superblock stepping
    assign w_step_x   = GRID_W'(1) << r_shift_cols;
    assign w_step_y   = GRID_W'(1) << r_shift_rows;
    assign w_inc_i    = (GRID_W+1)'(r_sub_i) + 1'b1;
    assign w_inc_j    = (GRID_W+1)'(r_sub_j) + 1'b1;
    assign w_next_x   = (GRID_W+1)'(r_super_x) + (GRID_W+1)'(w_step_x);
    assign w_next_y   = (GRID_W+1)'(r_super_y) + (GRID_W+1)'(w_step_y);
    assign w_has_tile = (r_tile_cols != '0) && (r_super_y < r_tile_rows);

    always_comb begin
        c_sub_i        = r_sub_i;
        c_sub_j        = r_sub_j;
        c_super_x      = r_super_x;
        c_super_y      = r_super_y;
        c_block_offset = r_block_offset;
        c_super_y_full = (GRID_W+1)'(r_super_y);
        if (w_inc_i >= (GRID_W+1)'(w_step_x)) begin
            c_sub_i = '0;
            if (w_inc_j >= (GRID_W+1)'(w_step_y)) begin
                c_sub_j        = '0;
                c_block_offset = r_block_offset + BO_W'(BLOCK_BYTES);
                if (w_next_x >= (GRID_W+1)'(r_tile_cols)) begin
                    c_super_x      = '0;
                    c_super_y      = w_next_y[GRID_W-1:0];
                    c_super_y_full = w_next_y;
                end else begin
                    c_super_x = w_next_x[GRID_W-1:0];
                end
            end else begin
                c_sub_j = w_inc_j[SUB_W-1:0];
            end
        end else begin
            c_sub_i = w_inc_i[SUB_W-1:0];
        end
    end

    assign w_done_after = (r_tile_cols == '0) || (c_super_y_full >= (GRID_W+1)'(r_tile_rows));

    // sizing arithmetic
    assign w_round_w   = (FRAME_W+1)'(r_frame_w) + (FRAME_W+1)'(TILE_PIX - 1);
    assign w_round_h   = (FRAME_W+1)'(r_frame_h) + (FRAME_W+1)'(TILE_PIX - 1);
    assign w_over      = w_prod > P_W'(MAX_BLOCKS);
    assign w_cols_wide = MUL_A_W'(r_w) << r_shift_cols;
    assign w_rows_wide = MUL_A_W'(r_h) << r_shift_rows;
    assign w_tiles     = w_prod[TILES_W-1:0];
    assign w_blk_sum   = ACC_W'(w_prod) + ACC_W'(AREA_ALIGN - 1);
    assign w_list_sum  = r_acc + (ACC_W'(w_tiles) << LIST_SHIFT) + ACC_W'(AREA_ALIGN - 1);
    assign w_desc_sum  = r_acc + (ACC_W'(w_tiles) << DESC_SHIFT)
                       + ACC_W'(DESC_BYTES) + ACC_W'(PAGE_BYTES - 1);
    assign w_fits      = CMP_W'(r_acc) <= CMP_W'(r_avail);

    // word fields
    assign w_x    = r_super_x[SUB_W-1:0] + r_sub_i;
    assign w_y    = r_super_y[SUB_W-1:0] + r_sub_j;
    assign w_addr = r_base + 32'(r_block_offset);

    assign w_emit = (r_state == S_ERR_SPACE) || (r_state == S_ERR_DONE)
                 || (r_state == S_TILE0) || (r_state == S_TILE1)
                 || (r_state == S_TILE2) || (r_state == S_TILE3)
                 || (r_state == S_TERM0) || (r_state == S_TERM1);
    assign w_load = w_emit && (!r_out_valid || !i_out_stall);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_restart) begin
                        n_state = S_MUL_WH;
                    end else if (!r_running) begin
                        n_state = S_ERR_DONE;
                    end else if (w_has_tile) begin
                        n_state = S_TILE0;
                    end else begin
                        n_state = S_TERM0;
                    end
                end
            end
            S_MUL_WH:    n_state = S_TEST;
            S_TEST:      n_state = w_over ? S_MUL_WH : S_MUL_BLK;
            S_MUL_BLK:   n_state = S_MUL_TILES;
            S_MUL_TILES: n_state = S_LIST;
            S_LIST:      n_state = S_DESC;
            S_DESC:      n_state = S_CHECK;
            S_CHECK:     n_state = w_fits ? S_IDLE : S_ERR_SPACE;
            S_ERR_SPACE: if (w_load) n_state = S_IDLE;
            S_ERR_DONE:  if (w_load) n_state = S_IDLE;
            S_TILE0:     if (w_load) n_state = S_TILE1;
            S_TILE1:     if (w_load) n_state = S_TILE2;
            S_TILE2:     if (w_load) n_state = S_TILE3;
            S_TILE3:     if (w_load) n_state = w_done_after ? S_TERM0 : S_IDLE;
            S_TERM0:     if (w_load) n_state = S_TERM1;
            S_TERM1:     if (w_load) n_state = S_IDLE;
        endcase
    end

    // datapath and shared multiplier control
    always_comb begin
        n_running      = r_running;
        n_w            = r_w;
        n_h            = r_h;
        n_shift_cols   = r_shift_cols;
        n_shift_rows   = r_shift_rows;
        n_tile_cols    = r_tile_cols;
        n_tile_rows    = r_tile_rows;
        n_super_x      = r_super_x;
        n_super_y      = r_super_y;
        n_sub_i        = r_sub_i;
        n_sub_j        = r_sub_j;
        n_block_offset = r_block_offset;
        n_acc          = r_acc;
        w_mul_en       = 1'b0;
        w_mul_a        = MUL_A_W'(r_w);
        w_mul_b        = B_W'(r_h);
        unique case (r_state)
            S_IDLE: begin
                if (w_accept && i_restart) begin
                    n_running      = 1'b0;
                    n_w            = w_round_w[FRAME_W:TILE_SHIFT];
                    n_h            = w_round_h[FRAME_W:TILE_SHIFT];
                    n_shift_cols   = '0;
                    n_shift_rows   = '0;
                    n_super_x      = '0;
                    n_super_y      = '0;
                    n_sub_i        = '0;
                    n_sub_j        = '0;
                    n_block_offset = '0;
                end
            end
            S_MUL_WH: begin
                w_mul_en = 1'b1;
            end
            S_TEST: begin
                if (w_over) begin
                    // halve the larger block dimension, rounding up
                    if (r_w >= r_h) begin
                        n_w          = GRID_W'((GRID_W+1)'(r_w) + 1'b1 >> 1);
                        n_shift_cols = r_shift_cols + 1'b1;
                    end else begin
                        n_h          = GRID_W'((GRID_W+1)'(r_h) + 1'b1 >> 1);
                        n_shift_rows = r_shift_rows + 1'b1;
                    end
                end else begin
                    n_tile_cols = w_cols_wide[GRID_W-1:0];
                    n_tile_rows = w_rows_wide[GRID_W-1:0];
                end
            end
            S_MUL_BLK: begin
                w_mul_en = 1'b1;
                w_mul_a  = w_prod[MUL_A_W-1:0];
                w_mul_b  = B_W'(BLOCK_BYTES);
            end
            S_MUL_TILES: begin
                w_mul_en = 1'b1;
                w_mul_a  = MUL_A_W'(r_tile_cols);
                w_mul_b  = B_W'(r_tile_rows);
                n_acc    = w_blk_sum & ~ACC_W'(AREA_ALIGN - 1);
            end
            S_LIST: begin
                n_acc = w_list_sum & ~ACC_W'(AREA_ALIGN - 1);
            end
            S_DESC: begin
                n_acc = w_desc_sum & ~ACC_W'(PAGE_BYTES - 1);
            end
            S_CHECK: begin
                n_running = w_fits;
            end
            S_TILE3: begin
                if (w_load) begin
                    n_sub_i        = c_sub_i;
                    n_sub_j        = c_sub_j;
                    n_super_x      = c_super_x;
                    n_super_y      = c_super_y;
                    n_block_offset = c_block_offset;
                end
            end
            S_TERM1: begin
                if (w_load) begin
                    n_running = 1'b0;
                end
            end
            S_ERR_SPACE, S_ERR_DONE, S_TILE0, S_TILE1, S_TILE2, S_TERM0: begin
            end
        endcase
    end

    // word for the current emit step
    always_comb begin
        e_word   = '0;
        e_last   = 1'b0;
        e_end    = 1'b0;
        e_status = STAT_OK;
        unique case (r_state)
            S_ERR_SPACE: begin
                e_last   = 1'b1;
                e_status = STAT_NO_SPACE;
            end
            S_ERR_DONE: begin
                e_last   = 1'b1;
                e_status = STAT_FINISHED;
            end
            S_TILE1: e_word = WORD_TILE_XY | {16'b0, w_y, w_x};
            S_TILE2: e_word = WORD_ADDR_SET | ({3'b0, w_addr[31:3]} & ~WORD_ADDR_MASK);
            S_TILE3: begin
                e_word = WORD_TILE_END;
                e_last = !w_done_after;
            end
            S_TERM1: begin
                e_word = WORD_STREAM_END;
                e_last = 1'b1;
                e_end  = 1'b1;
            end
            S_IDLE, S_MUL_WH, S_TEST, S_MUL_BLK, S_MUL_TILES, S_LIST, S_DESC,
            S_CHECK, S_TILE0, S_TERM0: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_running      <= 1'b0;
            r_out_valid    <= 1'b0;
            r_w            <= '0;
            r_h            <= '0;
            r_shift_cols   <= '0;
            r_shift_rows   <= '0;
            r_tile_cols    <= '0;
            r_tile_rows    <= '0;
            r_super_x      <= '0;
            r_super_y      <= '0;
            r_sub_i        <= '0;
            r_sub_j        <= '0;
            r_block_offset <= '0;
        end else begin
            r_state        <= n_state;
            r_running      <= n_running;
            r_w            <= n_w;
            r_h            <= n_h;
            r_shift_cols   <= n_shift_cols;
            r_shift_rows   <= n_shift_rows;
            r_tile_cols    <= n_tile_cols;
            r_tile_rows    <= n_tile_rows;
            r_super_x      <= n_super_x;
            r_super_y      <= n_super_y;
            r_sub_i        <= n_sub_i;
            r_sub_j        <= n_sub_j;
            r_block_offset <= n_block_offset;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        if (w_load) begin
            r_word   <= e_word;
            r_last   <= e_last;
            r_end    <= e_end;
            r_status <= e_status;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_word       = r_word;
    assign o_last       = r_last;
    assign o_stream_end = r_end;
    assign o_status     = r_status;

    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_stream_end) |-> o_last)
        else $error("stream end word without last");

    a_error_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status != STAT_OK)) |-> (o_word == '0) && o_last && !o_stream_end)
        else $error("error result with bad fields");

    a_tile_needs_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TILE0) |-> r_running)
        else $error("tile emitted while stream not running");

    a_sub_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_running |-> ((GRID_W+1)'(r_sub_i) < (GRID_W+1)'(w_step_x)))
        else $error("sub tile index beyond superblock");

    a_term_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TERM1 && w_load) |=> !r_running)
        else $error("stream still running after terminator");

endmodule
